[src/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define BFEA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bfea assertion failed");

// condition must never be seen outside reset
`define BFEA_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bfea forbidden condition seen");

`endif

[src/bfea_pkg.sv]
// shared widths, codes and defaults of the best-fit extent allocator
// no dependencies
`default_nettype none

package bfea_pkg;

    localparam int POS_W           = 40;
    localparam int LEN_W           = 32;
    localparam int END_W           = POS_W + 1;
    localparam int ENTRY_W         = POS_W + LEN_W;
    localparam int DEF_MAX_EXTENTS = 64;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_FULL    = 2'd2,
        ST_OVERLAP = 2'd3
    } status_t;

    typedef enum logic {
        CMD_FREE  = 1'b0,
        CMD_ALLOC = 1'b1
    } command_t;

endpackage

`default_nettype wire

[src/bfea_if.sv]
// request and response channels of the extent allocator
// depends on bfea_pkg
`default_nettype none

interface bfea_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [bfea_pkg::POS_W-1:0]  position;
    logic [bfea_pkg::LEN_W-1:0]  length;

    modport source (output valid, command, position, length, input ready);
    modport sink   (input valid, command, position, length, output ready);
endinterface

interface bfea_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [bfea_pkg::POS_W-1:0]  granted_position;

    modport source (output valid, status, granted_position, input ready);
    modport sink   (input valid, status, granted_position, output ready);
endinterface

`default_nettype wire

[src/bfea_table.sv]
// extent table: one write port, one read port with registered data
// depends on bfea_pkg
`default_nettype none

module bfea_table #(
    parameter int DEPTH = bfea_pkg::DEF_MAX_EXTENTS,
    parameter int IDXW  = $clog2(bfea_pkg::DEF_MAX_EXTENTS)
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [IDXW-1:0]               wr_addr,
    input  wire logic [bfea_pkg::ENTRY_W-1:0]  wr_data,
    input  wire logic [IDXW-1:0]               rd_addr,
    output logic      [bfea_pkg::ENTRY_W-1:0]  rd_data
);

    logic [bfea_pkg::ENTRY_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port with registered data
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[src/best_fit_extent_allocator_unit.sv]
// Best-fit extent allocator: free list in one table memory, scanned one entry per cycle.
// Steps: allocate and overlapping free go scan, decide, respond; other free adds merge-next and
// a table write (none when full); a zero-length or out-of-range free responds without a scan.
// One command at a time; the next request can be taken in the same cycle the response is offered.
// Reset: asynchronous; afterwards a clearing pass writes every table entry to zero, emptying the
// table, during which no request is taken.
`default_nettype none

module best_fit_extent_allocator_unit #(
    parameter int MAX_EXTENTS = bfea_pkg::DEF_MAX_EXTENTS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bfea_req_if.sink    req,
    bfea_rsp_if.source  rsp
);

    localparam int IDXW = $clog2(MAX_EXTENTS);
    localparam int CNTW = $clog2(MAX_EXTENTS + 1);
    localparam int POS_W = bfea_pkg::POS_W;
    localparam int LEN_W = bfea_pkg::LEN_W;
    localparam int END_W = bfea_pkg::END_W;
    localparam int ENTRY_W = bfea_pkg::ENTRY_W;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MAX_EXTENTS - 1);
    localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_EXTENTS);
    localparam logic [END_W-1:0] ADDR_END = {1'b1, {POS_W{1'b0}}};

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_MERGE_NEXT, S_WRITE, S_RESP
    } state_t;

    state_t                  state_reg;
    logic                    cmd_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [END_W-1:0]        end_reg;
    logic [CNTW-1:0]         rd_idx_reg;
    logic [IDXW-1:0]         ev_idx_reg;
    logic                    ev_valid_reg;
    logic [CNTW-1:0]         count_reg;

    logic                    ovl_reg;
    logic                    prev_hit_reg;
    logic [POS_W-1:0]        prev_start_reg;
    logic [LEN_W-1:0]        prev_len_reg;
    logic [IDXW-1:0]         prev_idx_reg;
    logic                    next_hit_reg;
    logic [LEN_W-1:0]        next_len_reg;
    logic [IDXW-1:0]         next_idx_reg;
    logic                    empty_hit_reg;
    logic [IDXW-1:0]         empty_idx_reg;
    logic                    best_hit_reg;
    logic [POS_W-1:0]        best_start_reg;
    logic [LEN_W-1:0]        best_len_reg;
    logic [IDXW-1:0]         best_idx_reg;

    logic [POS_W-1:0]        m_pos_reg;
    logic [LEN_W-1:0]        m_len_reg;
    logic                    slot_hit_reg;
    logic [IDXW-1:0]         slot_reg;

    bfea_pkg::status_t       res_status_reg;
    logic [POS_W-1:0]        res_granted_reg;
    logic                    rsp_valid_reg;
    bfea_pkg::status_t       rsp_status_reg;
    logic [POS_W-1:0]        rsp_granted_reg;

    logic                    wr_en;
    logic [IDXW-1:0]         wr_addr;
    logic [ENTRY_W-1:0]      wr_data;
    logic [ENTRY_W-1:0]      rd_data;
    logic                    rd_issue;

    logic [POS_W-1:0]        e_start;
    logic [LEN_W-1:0]        e_len;
    logic                    e_occ;
    logic [END_W-1:0]        e_end;
    logic [LEN_W:0]          p_sum;
    logic [LEN_W:0]          n_sum;
    logic                    merge_prev;
    logic                    merge_next;
    logic                    exact_fit;

    bfea_table #(
        .DEPTH (MAX_EXTENTS),
        .IDXW  (IDXW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_idx_reg[IDXW-1:0]),
        .rd_data (rd_data)
    );

    // handshake outputs
    assign req.ready            = (state_reg == S_IDLE);
    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = rsp_status_reg;
    assign rsp.granted_position = rsp_granted_reg;

    // entry under evaluation
    assign e_start = rd_data[ENTRY_W-1:LEN_W];
    assign e_len   = rd_data[LEN_W-1:0];
    assign e_occ   = (e_len != '0);
    assign e_end   = {1'b0, e_start} + END_W'(e_len);
    assign rd_issue = (state_reg == S_SCAN) && (rd_idx_reg < MAX_CNT);

    // merge checks, a merged length must fit in 32 bits
    assign p_sum      = {1'b0, prev_len_reg} + {1'b0, len_reg};
    assign merge_prev = prev_hit_reg && !p_sum[LEN_W];
    assign n_sum      = {1'b0, m_len_reg} + {1'b0, next_len_reg};
    assign merge_next = next_hit_reg && !n_sum[LEN_W];
    assign exact_fit  = (best_len_reg == len_reg);

    // table write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_idx_reg[IDXW-1:0];
        wr_data = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
            end
            S_DECIDE:
            begin
                wr_en   = (cmd_reg == bfea_pkg::CMD_ALLOC) && best_hit_reg;
                wr_addr = best_idx_reg;
                if (!exact_fit)
                begin
                    wr_data = {best_start_reg + POS_W'(len_reg), best_len_reg - len_reg};
                end
            end
            S_MERGE_NEXT:
            begin
                wr_en   = merge_next && slot_hit_reg;
                wr_addr = next_idx_reg;
            end
            S_WRITE:
            begin
                wr_en   = 1'b1;
                wr_addr = slot_reg;
                wr_data = {m_pos_reg, m_len_reg};
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // sequencer with registered response
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rd_idx_reg    <= '0;
            ev_valid_reg  <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            ev_valid_reg <= rd_issue;
            ev_idx_reg   <= rd_idx_reg[IDXW-1:0];
            if (rd_issue)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                    if (rd_idx_reg[IDXW-1:0] == LAST_IDX)
                    begin
                        rd_idx_reg <= '0;
                        state_reg  <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        cmd_reg        <= req.command;
                        pos_reg        <= req.position;
                        len_reg        <= req.length;
                        end_reg        <= {1'b0, req.position} + END_W'(req.length);
                        rd_idx_reg     <= '0;
                        ovl_reg        <= 1'b0;
                        prev_hit_reg   <= 1'b0;
                        next_hit_reg   <= 1'b0;
                        empty_hit_reg  <= 1'b0;
                        best_hit_reg   <= 1'b0;
                        res_granted_reg <= '0;
                        res_status_reg <= bfea_pkg::ST_OK;
                        if (req.command == bfea_pkg::CMD_FREE && req.length == '0)
                        begin
                            state_reg <= S_RESP;
                        end
                        else if (req.command == bfea_pkg::CMD_FREE &&
                                 ({1'b0, req.position} + END_W'(req.length)) > ADDR_END)
                        begin
                            res_status_reg <= bfea_pkg::ST_OVERLAP;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (ev_valid_reg)
                    begin
                        if (cmd_reg == bfea_pkg::CMD_FREE)
                        begin
                            if (e_occ)
                            begin
                                if ({1'b0, e_start} < end_reg && {1'b0, pos_reg} < e_end)
                                begin
                                    ovl_reg <= 1'b1;
                                end
                                if (e_end == {1'b0, pos_reg})
                                begin
                                    prev_hit_reg   <= 1'b1;
                                    prev_start_reg <= e_start;
                                    prev_len_reg   <= e_len;
                                    prev_idx_reg   <= ev_idx_reg;
                                end
                                if ({1'b0, e_start} == end_reg)
                                begin
                                    next_hit_reg <= 1'b1;
                                    next_len_reg <= e_len;
                                    next_idx_reg <= ev_idx_reg;
                                end
                            end
                            else if (!empty_hit_reg)
                            begin
                                empty_hit_reg <= 1'b1;
                                empty_idx_reg <= ev_idx_reg;
                            end
                        end
                        else if (e_occ && e_len >= len_reg &&
                                 (!best_hit_reg || e_len < best_len_reg ||
                                  (e_len == best_len_reg && e_start < best_start_reg)))
                        begin
                            best_hit_reg   <= 1'b1;
                            best_start_reg <= e_start;
                            best_len_reg   <= e_len;
                            best_idx_reg   <= ev_idx_reg;
                        end
                        if (ev_idx_reg == LAST_IDX)
                        begin
                            state_reg <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE:
                begin
                    if (cmd_reg == bfea_pkg::CMD_ALLOC)
                    begin
                        state_reg <= S_RESP;
                        if (!best_hit_reg)
                        begin
                            res_status_reg <= bfea_pkg::ST_NOFIT;
                        end
                        else
                        begin
                            res_granted_reg <= best_start_reg;
                            if (exact_fit)
                            begin
                                count_reg <= count_reg - 1'b1;
                            end
                        end
                    end
                    else if (ovl_reg)
                    begin
                        res_status_reg <= bfea_pkg::ST_OVERLAP;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        m_pos_reg    <= merge_prev ? prev_start_reg : pos_reg;
                        m_len_reg    <= merge_prev ? p_sum[LEN_W-1:0] : len_reg;
                        slot_hit_reg <= merge_prev;
                        slot_reg     <= prev_idx_reg;
                        state_reg    <= S_MERGE_NEXT;
                    end
                end
                S_MERGE_NEXT:
                begin
                    if (merge_next)
                    begin
                        m_len_reg <= n_sum[LEN_W-1:0];
                        state_reg <= S_WRITE;
                        if (slot_hit_reg)
                        begin
                            count_reg <= count_reg - 1'b1;
                        end
                        else
                        begin
                            slot_reg <= next_idx_reg;
                        end
                    end
                    else if (slot_hit_reg)
                    begin
                        state_reg <= S_WRITE;
                    end
                    else if (count_reg >= MAX_CNT || !empty_hit_reg)
                    begin
                        res_status_reg <= bfea_pkg::ST_FULL;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        slot_reg  <= empty_idx_reg;
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg   <= 1'b1;
                        rsp_status_reg  <= res_status_reg;
                        rsp_granted_reg <= res_granted_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[src/bfea_checker.sv]
// port-level checks of the extent allocator, bound to the top level
// depends on bfea_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bfea_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       req_valid,
    input wire logic                       req_ready,
    input wire logic                       rsp_valid,
    input wire logic                       rsp_ready,
    input wire logic [1:0]                 rsp_status,
    input wire logic [bfea_pkg::POS_W-1:0] rsp_granted
);

    logic rsp_fail;

    // any status other than ok
    assign rsp_fail = (rsp_status != bfea_pkg::ST_OK);

    // a waiting response stays offered
    `BFEA_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid)

    // a failed command never reports a position
    `BFEA_NEVER(a_granted_zero, clk, rst_n, rsp_valid && rsp_fail && rsp_granted != '0)

    // one command in work at a time
    `BFEA_ASSERT(a_busy_after_transfer, clk, rst_n, req_valid && req_ready |=> !req_ready)

endmodule

bind best_fit_extent_allocator_unit bfea_checker u_bfea_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_status  (rsp.status),
    .rsp_granted (rsp.granted_position)
);

`default_nettype wire
